FILE: rtl/core/section_address_translator_macros.svh
// ----------------------------------------------------------------------------
// Section address translator assertion macros
// Shared concurrent assertion helpers for the translator RTL.
// ----------------------------------------------------------------------------
`ifndef SECTION_ADDRESS_TRANSLATOR_MACROS_SVH
`define SECTION_ADDRESS_TRANSLATOR_MACROS_SVH

// Assertion checked only while reset is released.
`define SAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked at every clock edge, also during reset.
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sat_pkg.sv
// ----------------------------------------------------------------------------
// Section address translator package
// Shared types, function codes and result codes.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned MaxSectionsDef = 128;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;

  localparam logic [2:0] RC_MAPPED   = 3'd0;
  localparam logic [2:0] RC_TAIL     = 3'd1;
  localparam logic [2:0] RC_UNMAPPED = 3'd2;
  localparam logic [2:0] RC_APPENDED = 3'd3;
  localparam logic [2:0] RC_FULL     = 3'd4;
  localparam logic [2:0] RC_CLEARED  = 3'd5;

  typedef struct packed {
    logic [31:0] file_len;
    logic [31:0] file_base;
    logic [31:0] virtual_len;
    logic [31:0] virtual_base;
  } entry_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [32:0] file_position;
  } result_t;

endpackage

FILE: rtl/core/sat_table.sv
// ----------------------------------------------------------------------------
// Section table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sat_table
  import sat_pkg::*;
#(
  parameter int unsigned Depth = MaxSectionsDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: rtl/core/sat_scan.sv
// ----------------------------------------------------------------------------
// Section table controller
// Handles clear and append, and scans the table in order for a translation.
// ----------------------------------------------------------------------------
`include "section_address_translator_macros.svh"

module sat_scan
  import sat_pkg::*;
#(
  parameter int unsigned MaxSections = MaxSectionsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  entry_t      entry_i,
  input  logic [31:0] address_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int unsigned AddrW = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int unsigned CntW  = $clog2(MaxSections + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxSections);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HIT  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     dist_q, dist_d;
  logic [31:0]     fbase_q, fbase_d;
  result_t         res_q, res_d;

  logic            accept;
  logic            wr_en;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  entry_t          rd_data;

  logic [32:0]     diff;
  logic [31:0]     span;
  logic            in_span;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  assign wr_en = accept && !func_i[1] && (func_i == FUNC_APPEND) && (count_q < CntMax);

  assign diff    = {1'b0, addr_q} - {1'b0, rd_data.virtual_base};
  assign span    = (rd_data.virtual_len > rd_data.file_len) ? rd_data.virtual_len
                                                            : rd_data.file_len;
  assign in_span = !diff[32] && (diff[31:0] < span);

  assign rd_en = (accept && func_i[1] && (count_q != '0)) ||
                 ((state_q == ST_SCAN) && !in_span && (idx_q < count_q));
  assign rd_addr = (state_q == ST_SCAN) ? idx_q[AddrW-1:0] : '0;

  sat_table #(
    .Depth(MaxSections)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[AddrW-1:0]),
    .wr_data_i(entry_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    addr_d  = addr_q;
    dist_d  = dist_q;
    fbase_d = fbase_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.file_position = '0;
          if (func_i[1]) begin
            addr_d = address_i;
            if (count_q == '0) begin
              res_d.result_code = RC_UNMAPPED;
              state_d = ST_RESP;
            end else begin
              idx_d   = CntW'(1);
              state_d = ST_SCAN;
            end
          end else if (func_i == FUNC_APPEND) begin
            if (count_q < CntMax) begin
              count_d = count_q + CntW'(1);
              res_d.result_code = RC_APPENDED;
            end else begin
              res_d.result_code = RC_FULL;
            end
            state_d = ST_RESP;
          end else begin
            count_d = '0;
            res_d.result_code = RC_CLEARED;
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (in_span) begin
          if (diff[31:0] >= rd_data.file_len) begin
            res_d.result_code = RC_TAIL;
            state_d = ST_RESP;
          end else begin
            dist_d  = diff[31:0];
            fbase_d = rd_data.file_base;
            state_d = ST_HIT;
          end
        end else if (idx_q < count_q) begin
          idx_d = idx_q + CntW'(1);
        end else begin
          res_d.result_code = RC_UNMAPPED;
          state_d = ST_RESP;
        end
      end
      ST_HIT: begin
        res_d.file_position = {1'b0, fbase_q} + {1'b0, dist_q};
        res_d.result_code   = RC_MAPPED;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    dist_q  <= dist_d;
    fbase_q <= fbase_d;
    res_q   <= res_d;
  end

  `SAT_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || (count_q <= CntMax),
                     "entry count above table depth")
  `SAT_ASSERT(a_read_valid, clk_i, rst_ni, rd_en |-> (CntW'(rd_addr) < count_q),
              "read of entry beyond count")
  `SAT_ASSERT(a_write_room, clk_i, rst_ni, wr_en |-> (count_q < CntMax),
              "write into full table")
  `SAT_ASSERT(a_scan_index, clk_i, rst_ni,
              (state_q == ST_SCAN) |-> ((idx_q != '0) && (idx_q <= count_q)),
              "scan index out of range")
  `SAT_ASSERT(a_result_hold, clk_i, rst_ni,
              (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)),
              "pending result dropped")

endmodule

FILE: rtl/core/section_address_translator.sv
// ----------------------------------------------------------------------------
// Section address translator
// Ordered section table with clear, append and in-order address translation.
// ----------------------------------------------------------------------------
// Clear and append results go to the scan result register, then to the output register.
// A translation reads the table in order, one table read per cycle, until an entry covers
// the address or all entries are examined; a mapped address adds a HIT step.
// A new item is taken only in the cycle after the previous result moves to the output.
// Reset empties the table; entry contents are not cleared and need no sweep.
module section_address_translator
  import sat_pkg::*;
#(
  parameter int unsigned MaxSections = MaxSectionsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // virtual_base[31:0], virtual_len[63:32], file_base[95:64], file_len[127:96],
  // address_in[159:128]
  input  logic [159:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // file_position[32:0], zero padding[39:33]
  output logic [39:0]  m_axis_tdata,
  // result_code[2:0]
  output logic [2:0]   m_axis_tuser
);

  entry_t  entry;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_q;
  result_t out_q;

  assign entry.virtual_base = s_axis_tdata[31:0];
  assign entry.virtual_len  = s_axis_tdata[63:32];
  assign entry.file_base    = s_axis_tdata[95:64];
  assign entry.file_len     = s_axis_tdata[127:96];

  sat_scan #(
    .MaxSections(MaxSections)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .entry_i    (entry),
    .address_i  (s_axis_tdata[159:128]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.file_position};
  assign m_axis_tuser  = out_q.result_code;

endmodule

FILE: sim/section_address_translator_test.sv
// ----------------------------------------------------------------------------
// Section address translator testbench
// Drives clear, append and translate transactions into the section table
// and checks every result against its directed expectation or an internal table
// model. A directed table covers empty, boundary, wrap, tail and overlap cases.
// Random episodes then build small tables, fill the table past its limit twice
// and translate addresses aimed at section edges. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module section_address_translator_test;
  import sat_pkg::*;

  localparam int unsigned MaxSect = MaxSectionsDef;
  localparam logic [1:0] FUNC_TRANSLATE = 2'd2;
  localparam logic [1:0] FUNC_TRANSLATE_ALT = 2'd3;
  localparam int unsigned RandomOps = 625;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] vbase;
    logic [31:0] vlen;
    logic [31:0] fbase;
    logic [31:0] flen;
    logic [31:0] addr;
  } section_op_t;

  typedef struct {
    section_op_t op;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  logic [31:0]  tbl_vbase [MaxSect];
  logic [31:0]  tbl_vlen  [MaxSect];
  logic [31:0]  tbl_fbase [MaxSect];
  logic [31:0]  tbl_flen  [MaxSect];
  int unsigned  tbl_count = 0;

  result_t      pending_outcomes [$];
  dir_row_t     dir_rows [$];
  int unsigned  code_seen [8];
  int unsigned  ops_accepted = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  int unsigned  drains_done = 0;
  int unsigned  fills_done = 0;
  int unsigned  hold_offs_done = 0;
  bit           hold_off_req = 1'b0;

  section_address_translator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t apply_section_op(section_op_t op);
    result_t     r;
    int unsigned i;
    bit          found;
    logic [31:0] span;
    logic [31:0] delta;
    logic [32:0] span_end;
    r.file_position = '0;
    r.result_code = RC_UNMAPPED;
    found = 1'b0;
    if (op.func[1]) begin
      for (i = 0; i < tbl_count && !found; i++) begin
        span = (tbl_vlen[i] > tbl_flen[i]) ? tbl_vlen[i] : tbl_flen[i];
        span_end = {1'b0, tbl_vbase[i]} + {1'b0, span};
        if (op.addr >= tbl_vbase[i] && {1'b0, op.addr} < span_end) begin
          found = 1'b1;
          delta = op.addr - tbl_vbase[i];
          if (delta >= tbl_flen[i]) begin
            r.result_code = RC_TAIL;
          end else begin
            r.result_code = RC_MAPPED;
            r.file_position = {1'b0, tbl_fbase[i]} + {1'b0, delta};
          end
        end
      end
    end else if (op.func == FUNC_APPEND) begin
      if (tbl_count < MaxSect) begin
        tbl_vbase[tbl_count] = op.vbase;
        tbl_vlen[tbl_count] = op.vlen;
        tbl_fbase[tbl_count] = op.fbase;
        tbl_flen[tbl_count] = op.flen;
        tbl_count++;
        r.result_code = RC_APPENDED;
      end else begin
        r.result_code = RC_FULL;
      end
    end else begin
      tbl_count = 0;
      r.result_code = RC_CLEARED;
    end
    return r;
  endfunction

  function automatic void add_row(logic [1:0] func, logic [31:0] vbase, logic [31:0] vlen,
                                  logic [31:0] fbase, logic [31:0] flen, logic [31:0] addr,
                                  bit typed, logic [2:0] code, logic [32:0] pos);
    dir_row_t row;
    row.op = {func, vbase, vlen, fbase, flen, addr};
    row.typed = typed;
    row.res.result_code = code;
    row.res.file_position = pos;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(1, 32'h1000);
      4: return $urandom_range(1, 32'h10_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_base();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 32'h1000);
      1: return $urandom_range(0, 32'h1_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] aim_address();
    int unsigned idx;
    logic [31:0] vb;
    logic [31:0] fl;
    logic [31:0] span;
    if (tbl_count == 0 || $urandom_range(0, 9) == 0) return $urandom;
    idx = $urandom_range(0, tbl_count - 1);
    vb = tbl_vbase[idx];
    fl = tbl_flen[idx];
    span = (tbl_vlen[idx] > fl) ? tbl_vlen[idx] : fl;
    case ($urandom_range(0, 7))
      0: return vb;
      1: return vb + fl - 32'd1;
      2: return vb + fl;
      3: return vb + span - 32'd1;
      4: return vb + span;
      5: return vb - 32'd1;
      6: return vb + ((span == 0) ? 32'd0 : $urandom_range(0, span - 1));
      default: return vb + ($urandom & 32'hFF);
    endcase
  endfunction

  function automatic section_op_t rand_op(logic [1:0] func);
    section_op_t op;
    op.func = func;
    op.vbase = rand_base();
    op.vlen = rand_len();
    op.fbase = $urandom;
    op.flen = rand_len();
    op.addr = func[1] ? aim_address() : $urandom;
    return op;
  endfunction

  task automatic send_item(section_op_t op, bit typed, result_t typed_res);
    int unsigned gap;
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {op.addr, op.flen, op.fbase, op.vlen, op.vbase};
    s_axis_tuser <= op.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_section_op(op);
    code_seen[predicted.result_code]++;
    pending_outcomes.push_back(typed ? typed_res : predicted);
    ops_accepted++;
  endtask

  task automatic drain_outcomes();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
    drains_done++;
  endtask

  task automatic send_random(logic [1:0] func);
    result_t none;
    none = '0;
    if ($urandom_range(0, 99) < 8) begin
      send_item({2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom},
                1'b0, none);
    end
    send_item(rand_op(func), 1'b0, none);
  endtask

  task automatic run_episode(bit fill);
    int unsigned n_app;
    int unsigned n_tr;
    if (fill || $urandom_range(0, 9) < 7) send_random(FUNC_CLEAR);
    n_app = fill ? MaxSect + $urandom_range(1, 3) : $urandom_range(1, 8);
    repeat (n_app) send_random(FUNC_APPEND);
    n_tr = fill ? 8 : $urandom_range(3, 12);
    repeat (n_tr) send_random(($urandom_range(0, 3) == 0) ? FUNC_TRANSLATE_ALT : FUNC_TRANSLATE);
  endtask

  // Receiver: varying ready patterns, plus one long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned k;
    forever begin
      if (hold_off_req) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      for (k = 0; k < len; k++) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (k % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.file_position = m_axis_tdata[32:0];
      got.result_code = m_axis_tuser;
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("Unexpected result: code %0d position 0x%09h", got.result_code,
                   got.file_position);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.result_code !== want.result_code || got.file_position !== want.file_position)
        begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("Mismatch at result %0d: expected code %0d position 0x%09h, got %0d 0x%09h",
                     results_seen, want.result_code, want.file_position, got.result_code,
                     got.file_position);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    result_t none;
    int unsigned n_directed;
    none = '0;
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, RC_CLEARED, 33'h0);
    add_row(FUNC_APPEND, 32'h1000, 32'h200, 32'h400, 32'h100, 32'h0, 1'b1, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1000, 1'b1, RC_MAPPED, 33'h400);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10FF, 1'b1, RC_MAPPED, 33'h4FF);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1100, 1'b1, RC_TAIL, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h11FF, 1'b1, RC_TAIL, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1200, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0FFF, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_APPEND, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
            1'b1, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
            1'b1, RC_MAPPED, 33'h1_0000_000E);
    add_row(FUNC_TRANSLATE_ALT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1000, 1'b1, RC_MAPPED, 33'h400);
    add_row(FUNC_APPEND, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0,
            1'b1, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1180, 1'b1, RC_TAIL, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2000, 1'b1, RC_TAIL, 33'h0);
    add_row(FUNC_TRANSLATE_ALT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5, 1'b1, RC_TAIL, 33'h0);
    add_row(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1, RC_CLEARED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1000, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_APPEND, 32'h8000_0000, 32'h10, 32'hFFFF_FF00, 32'h100, 32'h0,
            1'b1, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_00FF,
            1'b1, RC_MAPPED, 33'hFFFF_FFFF);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0100, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_APPEND, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, RC_UNMAPPED, 33'h0);
    add_row(FUNC_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA, 32'h33, 32'h0,
            1'b0, RC_APPENDED, 33'h0);
    add_row(FUNC_TRANSLATE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0010, 1'b0, RC_MAPPED, 33'h0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
    n_directed = ops_accepted;
    drain_outcomes();

    // The receiver holds off while the sender keeps offering transactions.
    hold_off_req = 1'b1;
    while (ops_accepted < n_directed + RandomOps) begin
      if (fills_done < 2 && ops_accepted >= n_directed + (fills_done == 0 ? 150 : 400)) begin
        run_episode(1'b1);
        fills_done++;
        drain_outcomes();
      end else begin
        run_episode(1'b0);
      end
    end
    drain_outcomes();
    repeat (MaxSect + 8) @(posedge clk_i);

    $display("Ran %0d transactions (%0d directed), %0d table fills, %0d receiver hold-offs.",
             ops_accepted, n_directed, fills_done, hold_offs_done);
    $display("Results: %0d mapped, %0d tail, %0d unmapped, %0d appended, %0d full, %0d cleared.",
             code_seen[RC_MAPPED], code_seen[RC_TAIL], code_seen[RC_UNMAPPED],
             code_seen[RC_APPENDED], code_seen[RC_FULL], code_seen[RC_CLEARED]);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_outcomes.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
